FILE: sv/dss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the descending sort core and its cells.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned VALUE_W   = 16;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sorted_value;
    logic               last_out;
  } out_item_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               valid;
    logic               take;
  } cell_link_t;

endpackage

FILE: sv/dss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_cell
// One slot of the sorting chain: holds a value, inserts in order, shifts out.
// ----------------------------------------------------------------------------
module dss_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dss_pkg::cell_ctrl_t         ctrl,
  input  logic [dss_pkg::VALUE_W-1:0] x,
  input  dss_pkg::cell_link_t         left,
  input  dss_pkg::cell_link_t         right,
  output dss_pkg::cell_link_t         link
);

  logic [dss_pkg::VALUE_W-1:0] value_r;
  logic [dss_pkg::VALUE_W-1:0] value_nxt;
  logic                        valid_r;
  logic                        valid_nxt;
  logic                        take;

  // A held value moves right when the new value is larger; the first empty
  // slot fills from its left neighbor or with the new value.
  assign take = ctrl.ins && (valid_r ? (x > value_r) : left.valid);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    priority if (ctrl.shift) begin
      value_nxt = right.value;
      valid_nxt = right.valid;
    end else if (take) begin
      value_nxt = left.take ? left.value : x;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

  assign link.value = value_r;
  assign link.valid = valid_r;
  assign link.take  = take;

endmodule

FILE: sv/descending_selection_sort_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descending_selection_sort_core
// Sorts a block of up to DEPTH unsigned values into non-increasing order.
// ----------------------------------------------------------------------------
// Values are taken one per cycle and inserted in order into a chain of DEPTH
// cells. The transfer that carries last_in closes the block; from the next
// cycle the chain shifts toward its head and emits one result per cycle
// while out_stall is low. The input is stalled during the drain and is
// taken again in the cycle after the final result is loaded. Values beyond
// DEPTH are dropped.
module descending_selection_sort_core #(
  parameter int unsigned DEPTH = dss_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dss_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dss_pkg::out_item_t out_data
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t                      state_r;
  logic [CNT_W-1:0]            count_r;
  logic                        out_valid_r;
  dss_pkg::out_item_t          out_data_r;
  dss_pkg::cell_ctrl_t         ctrl;
  dss_pkg::cell_link_t         links [DEPTH];
  dss_pkg::cell_link_t         head_left;
  dss_pkg::cell_link_t         tail_right;
  logic                        in_xfer;
  logic                        load_out;

  assign in_stall = (state_r == ST_DRAIN);
  assign in_xfer  = in_valid && !in_stall;
  assign ctrl.ins = in_xfer && (count_r < CNT_W'(DEPTH));
  assign load_out = (state_r == ST_DRAIN) && (count_r != '0) &&
                    (!out_valid_r || !out_stall);
  assign ctrl.shift = load_out;

  assign head_left.value  = '0;
  assign head_left.valid  = 1'b1;
  assign head_left.take   = 1'b0;
  assign tail_right.value = '0;
  assign tail_right.valid = 1'b0;
  assign tail_right.take  = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dss_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .x     (in_data.value),
      .left  ((i == 0) ? head_left : links[(i == 0) ? 0 : i - 1]),
      .right ((i == DEPTH - 1) ? tail_right : links[(i == DEPTH - 1) ? i : i + 1]),
      .link  (links[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (ctrl.ins) begin
            count_r <= count_r + CNT_W'(1);
          end
          if (in_xfer && in_data.last_in) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (load_out) begin
            count_r <= count_r - CNT_W'(1);
            if (count_r == CNT_W'(1)) begin
              state_r <= ST_LOAD;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (load_out) begin
      out_data_r.sorted_value <= links[0].value;
      out_data_r.last_out     <= (count_r == CNT_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
